### design/iqd_pkg.sv
// ----------------------------------------------------------------------------
// iqd_pkg: shared definitions of the I/Q demodulator
// Mode codes, configuration register indexes and fixed port widths.
// ----------------------------------------------------------------------------
package iqd_pkg;

	localparam int PORT_W          = 16;
	localparam int IN_DATA_W       = 2 * PORT_W;
	localparam int MODE_W          = 2;
	localparam int GAIN_W          = 8;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [MODE_W-1:0] MODE_AM  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_USB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LSB = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RAW = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 8'd1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd1;

endpackage

### design/iqd_fifo.sv
// ----------------------------------------------------------------------------
// iqd_fifo: item queue between front and back
// A small first-in first-out store with a fill count.
// ----------------------------------------------------------------------------
module iqd_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = iqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/iqd_front.sv
// ----------------------------------------------------------------------------
// iqd_front: input side of the I/Q demodulator
// Accepts I/Q pairs, forms the energy, sum, difference or raw word for the
// current mode and pushes one queue entry per item.
// ----------------------------------------------------------------------------
module iqd_front #(
	parameter int SAMPLE_BITS = iqd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [iqd_pkg::MODE_W-1:0]     mode,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [iqd_pkg::IN_DATA_W-1:0]  s_tdata,   // i_sample[15:0], q_sample[31:16]
	input  logic                           s_tlast,   // block_end
	output logic                           push,
	output logic [2*SAMPLE_BITS+2:0]       push_data,
	input  logic                           full
);

	localparam int S = SAMPLE_BITS;
	localparam int W = 2 * SAMPLE_BITS;

	logic [S-1:0] i_w;
	logic [S-1:0] q_w;
	logic [S-1:0] i_abs;
	logic [S-1:0] q_abs;
	logic [W-1:0] energy;
	logic [W-1:0] word;
	logic         seen_q;

	assign i_w   = s_tdata[S-1:0];
	assign q_w   = s_tdata[iqd_pkg::PORT_W+S-1:iqd_pkg::PORT_W];
	assign i_abs = i_w[S-1] ? (~i_w + 1'b1) : i_w;
	assign q_abs = q_w[S-1] ? (~q_w + 1'b1) : q_w;
	assign energy = W'(i_abs) * W'(i_abs) + W'(q_abs) * W'(q_abs);

	always_comb begin
		case (mode)
			iqd_pkg::MODE_AM:  word = energy;
			iqd_pkg::MODE_USB: word = W'(S'(i_w + q_w));
			iqd_pkg::MODE_LSB: word = W'(S'(i_w - q_w));
			default:           word = {q_w, i_w};
		endcase
	end

	// Ready is held low after reset until seen_q is set by a clock edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign s_tready  = seen_q && !full;
	assign push      = s_tvalid && s_tready;
	assign push_data = {s_tlast, mode, word};

endmodule

### design/iqd_back.sv
// ----------------------------------------------------------------------------
// iqd_back: execution side of the I/Q demodulator
// Pipelined square root of AM items, one result bit per stage, then gain
// scaling and an output stage that splits raw items into two results.
// ----------------------------------------------------------------------------
module iqd_back #(
	parameter int SAMPLE_BITS = iqd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [iqd_pkg::GAIN_W-1:0]    gain,
	input  logic [2*SAMPLE_BITS+2:0]      head_data,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [iqd_pkg::PORT_W-1:0]    m_tdata,   // audio_sample[15:0]
	output logic                          m_tuser,   // last_of_item
	output logic                          m_tlast    // block_done
);

	localparam int S  = SAMPLE_BITS;
	localparam int W  = 2 * SAMPLE_BITS;
	localparam int PW = S + iqd_pkg::GAIN_W;

	logic [W-1:0]               n_s    [S];
	logic [W-1:0]               root_s [S];
	logic [iqd_pkg::MODE_W-1:0] op_s   [S];
	logic                       end_s  [S];
	logic                       vld_s  [S];

	logic [W-1:0]               n_nx   [S];
	logic [W-1:0]               root_nx[S];
	logic [iqd_pkg::MODE_W-1:0] op_nx  [S];
	logic                       end_nx [S];
	logic                       vld_nx [S];

	logic en;
	logic out_free;
	logic out_take;

	logic                       out_valid_q;
	logic [iqd_pkg::PORT_W-1:0] out_data_q;
	logic                       out_last_q;
	logic                       out_done_q;
	logic                       pend_q;
	logic [iqd_pkg::PORT_W-1:0] pend_data_q;
	logic                       pend_done_q;

	logic [S-1:0]               fin_val;
	logic [PW-1:0]              prod;
	logic signed [S-1:0]        scaled;
	logic signed [S-1:0]        raw_i;
	logic signed [S-1:0]        raw_q;

	assign out_free = !out_valid_q || m_tready;
	assign out_take = out_free && !pend_q;
	assign en       = !vld_s[S-1] || out_take;
	assign pop      = en && !empty;

	always_comb begin
		for (int k = 0; k < S; k++) begin
			logic [W-1:0]               n_in;
			logic [W-1:0]               r_in;
			logic [W-1:0]               bit_k;
			logic [W-1:0]               trial;
			logic [iqd_pkg::MODE_W-1:0] op_in;
			n_in  = (k == 0) ? head_data[W-1:0] : n_s[(k == 0) ? 0 : k - 1];
			r_in  = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k - 1];
			op_in = (k == 0) ? head_data[W+1:W] : op_s[(k == 0) ? 0 : k - 1];
			bit_k = W'(1) << (W - 2 - 2 * k);
			trial = r_in + bit_k;
			op_nx[k]  = op_in;
			end_nx[k] = (k == 0) ? head_data[W+2] : end_s[(k == 0) ? 0 : k - 1];
			vld_nx[k] = (k == 0) ? !empty : vld_s[(k == 0) ? 0 : k - 1];
			if (op_in == iqd_pkg::MODE_AM && n_in >= trial) begin
				n_nx[k]    = n_in - trial;
				root_nx[k] = (r_in >> 1) + bit_k;
			end else if (op_in == iqd_pkg::MODE_AM) begin
				n_nx[k]    = n_in;
				root_nx[k] = r_in >> 1;
			end else begin
				n_nx[k]    = n_in;
				root_nx[k] = r_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < S; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < S; k++) begin
				vld_s[k] <= vld_nx[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < S; k++) begin
				n_s[k]    <= n_nx[k];
				root_s[k] <= root_nx[k];
				op_s[k]   <= op_nx[k];
				end_s[k]  <= end_nx[k];
			end
		end
	end

	assign fin_val = (op_s[S-1] == iqd_pkg::MODE_AM) ? root_s[S-1][S-1:0] : n_s[S-1][S-1:0];
	assign prod    = PW'(fin_val) * PW'(gain);
	assign scaled  = prod[S-1:0];
	assign raw_i   = n_s[S-1][S-1:0];
	assign raw_q   = n_s[S-1][W-1:S];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (vld_s[S-1]) begin
				out_valid_q <= 1'b1;
				pend_q      <= (op_s[S-1] == iqd_pkg::MODE_RAW);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_data_q <= pend_data_q;
				out_last_q <= 1'b1;
				out_done_q <= pend_done_q;
			end else if (op_s[S-1] == iqd_pkg::MODE_RAW) begin
				out_data_q  <= iqd_pkg::PORT_W'(raw_i);
				out_last_q  <= 1'b0;
				out_done_q  <= 1'b0;
				pend_data_q <= iqd_pkg::PORT_W'(raw_q);
				pend_done_q <= end_s[S-1];
			end else begin
				out_data_q <= iqd_pkg::PORT_W'(scaled);
				out_last_q <= 1'b1;
				out_done_q <= end_s[S-1];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_last_q;
	assign m_tlast  = out_done_q;

endmodule

### design/iq_demodulator.sv
// ----------------------------------------------------------------------------
// iq_demodulator: AM envelope and SSB demodulator for I/Q pairs
// Configuration registers, front end, item queue and execution back end.
// ----------------------------------------------------------------------------
// An accepted pair passes through the item queue, the square-root pipeline and
// the output register before its first result is presented.
// Throughput: one pair per cycle in AM, USB and LSB modes unless the output
// stalls; in raw mode the pipeline holds while the single result port sends Q.
// The square root runs as a SAMPLE_BITS-stage pipeline, one root bit a stage.
// Reset: mode 0, gain 1, queue and pipeline empty; ready rises on a later clock.
// ----------------------------------------------------------------------------
module iq_demodulator #(
	parameter int SAMPLE_BITS = iqd_pkg::SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = iqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iqd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iqd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [iqd_pkg::IN_DATA_W-1:0]   s_tdata,   // i_sample[15:0], q_sample[31:16]
	input  logic                            s_tlast,   // block_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [iqd_pkg::PORT_W-1:0]      m_tdata,   // audio_sample[15:0]
	output logic                            m_tuser,   // last_of_item
	output logic                            m_tlast    // block_done
);

	localparam int EW = 2 * SAMPLE_BITS + 3;

	logic [iqd_pkg::MODE_W-1:0] mode_q;
	logic [iqd_pkg::GAIN_W-1:0] gain_q;
	logic                       push;
	logic [EW-1:0]              push_data;
	logic                       full;
	logic                       pop;
	logic [EW-1:0]              head_data;
	logic                       empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iqd_pkg::MODE_AM;
			gain_q <= iqd_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				iqd_pkg::CFG_MODE: mode_q <= cfg_data[iqd_pkg::MODE_W-1:0];
				iqd_pkg::CFG_GAIN: gain_q <= cfg_data[iqd_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	iqd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	iqd_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head_data(head_data),
		.empty    (empty)
	);

	iqd_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.head_data(head_data),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
